/* src/assert_macros.svh */
// assertion macros shared by the central moments block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define RCM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rcm assertion failed");

// condition must never be true outside reset
`define RCM_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rcm forbidden condition seen");

`else

`define RCM_ASSERT(lbl, clk, rst, prop)
`define RCM_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* src/rcm_pkg.sv */
// shared constants, types and saturating helpers of the central moments block
`default_nettype none

package rcm_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 24;
   localparam int X_BITS        = SAMPLE_BITS + 16;
   localparam int DELTA_BITS    = ((X_BITS > 32) ? X_BITS : 32) + 1;
   localparam int QUOT_BITS     = DELTA_BITS - 1;
   localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS);
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 248;

   // right shift applied to a 128-bit product
   typedef enum logic [1:0] {
      SH_0  = 2'd0,
      SH_16 = 2'd1,
      SH_32 = 2'd2
   } shift_type;

   // one pass of the shared multiplier per step
   typedef enum logic [3:0] {
      ST_NN  = 4'd0,
      ST_T   = 4'd1,
      ST_TMP = 4'd2,
      ST_DN2 = 4'd3,
      ST_E   = 4'd4,
      ST_U1  = 4'd5,
      ST_V   = 4'd6,
      ST_U2  = 4'd7,
      ST_W   = 4'd8,
      ST_T3  = 4'd9,
      ST_A1  = 4'd10,
      ST_A   = 4'd11,
      ST_B0  = 4'd12,
      ST_B   = 4'd13
   } step_type;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_PREP = 9'b000000010,
      S_DIV  = 9'b000000100,
      S_ISSU = 9'b000001000,
      S_WAIT = 9'b000010000,
      S_FIN1 = 9'b000100000,
      S_FIN2 = 9'b001000000,
      S_FIN3 = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      shift_type   shift;
   } mul_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] res;
      logic        ovf;
   } mul_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [QUOT_BITS-1:0]  dividend;
      logic [COUNT_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [QUOT_BITS-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic [63:0] val;
      logic        ovf;
   } sat_type;

   // magnitude of a signed 64-bit value
   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   // apply a sign to a magnitude, clamp to the signed range
   function automatic sat_type to_signed(input logic [63:0] m, input logic neg);
      sat_type r;
      r.ovf = 1'b0;
      if (!neg) begin
         if (m[63]) begin
            r.val = 64'h7FFF_FFFF_FFFF_FFFF;
            r.ovf = 1'b1;
         end else begin
            r.val = m;
         end
      end else begin
         if (m[63] && (|m[62:0])) begin
            r.val = 64'h8000_0000_0000_0000;
            r.ovf = 1'b1;
         end else begin
            r.val = 64'd0 - m;
         end
      end
      return r;
   endfunction

   function automatic sat_type sadd(input logic [63:0] a, input logic [63:0] b);
      sat_type     r;
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      r.ovf = s[64] != s[63];
      if (r.ovf) begin
         r.val = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         r.val = s[63:0];
      end
      return r;
   endfunction

   function automatic sat_type ssub(input logic [63:0] a, input logic [63:0] b);
      sat_type     r;
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      r.ovf = s[64] != s[63];
      if (r.ovf) begin
         r.val = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         r.val = s[63:0];
      end
      return r;
   endfunction

   function automatic sat_type uadd(input logic [63:0] a, input logic [63:0] b);
      sat_type     r;
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      r.ovf = s[64];
      r.val = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
      return r;
   endfunction

   function automatic sat_type usub(input logic [63:0] a, input logic [63:0] b);
      sat_type r;
      r.ovf = b > a;
      r.val = r.ovf ? 64'd0 : (a - b);
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/rcm_mul.sv */
// shared 64x64 multiplier from 32x32 partial products, with shift and saturation
`default_nettype none

module rcm_mul
   import rcm_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic [2:0] LAST_PART = 3'd3;
   localparam logic [2:0] LAST_ADD  = 3'd4;
   localparam logic [2:0] RES_CYC   = 3'd5;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, b_ff;
   shift_type    sh_ff;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   off_ff, off_in;
   logic [127:0] acc_ff;
   logic [63:0]  res_ff, res_in;
   logic         ovf_ff, ovf_in;
   logic [31:0]  a_half, b_half;
   logic [63:0]  shr_val;
   logic         shr_ovf;

   // partial product select
   always_comb begin
      a_half = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp_in  = {32'd0, a_half} * {32'd0, b_half};
      off_in = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
   end

   // shift right and saturate to 64 bits
   always_comb begin
      case (sh_ff)
         SH_0: begin
            shr_val = acc_ff[63:0];
            shr_ovf = |acc_ff[127:64];
         end
         SH_16: begin
            shr_val = acc_ff[79:16];
            shr_ovf = |acc_ff[127:80];
         end
         SH_32: begin
            shr_val = acc_ff[95:32];
            shr_ovf = |acc_ff[127:96];
         end
         default: begin
            shr_val = acc_ff[63:0];
            shr_ovf = |acc_ff[127:64];
         end
      endcase
      res_in = shr_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : shr_val;
      ovf_in = shr_ovf;
   end

   // sequencing of the partial products
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == RES_CYC) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands, partial product and accumulator
   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff   <= req.a;
         b_ff   <= req.b;
         sh_ff  <= req.shift;
         acc_ff <= 128'd0;
      end else if (busy_ff) begin
         if (cnt_ff <= LAST_PART) begin
            pp_ff  <= pp_in;
            off_ff <= off_in;
         end
         if ((cnt_ff != 3'd0) && (cnt_ff <= LAST_ADD)) begin
            acc_ff <= acc_ff + ({64'd0, pp_ff} << {off_ff, 5'd0});
         end
         if (cnt_ff == RES_CYC) begin
            res_ff <= res_in;
            ovf_ff <= ovf_in;
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;
   assign rsp.ovf  = ovf_ff;

endmodule

`default_nettype wire

/* src/rcm_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module rcm_div
   import rcm_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [QUOT_BITS-1:0]    quo_ff, quo_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   dvs_ff;
   logic [COUNT_BITS:0]     rem_sh, diff;
   logic                    ge;

   // one trial subtraction
   always_comb begin
      rem_sh = {rem_ff, quo_ff[QUOT_BITS-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      ge     = !diff[COUNT_BITS];
      rem_in = ge ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      quo_in = {quo_ff[QUOT_BITS-2:0], ge};
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // dividend shifts out as the quotient shifts in
   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

`default_nettype wire

/* src/running_central_moments_order4_top.sv */
// top level of the one-pass central moments block, orders two to four
`default_nettype none
`include "assert_macros.svh"

// Each accepted sample updates the count, the Q15.16 mean and the central
// moment sums M2, M3 and M4 and returns one result with all of them and a
// sticky saturation flag. The block takes one sample at a time and is not
// ready while it works. A sample goes through setup, the serial divide
// delta / n (one quotient bit per cycle), fourteen passes through the single
// shared 64x64 multiplier (each built from four 32x32 partial products),
// saturating accumulation in states S_FIN1 to S_FIN3 and the load of the
// output register. A finished result waits in that register, so the next
// sample is taken while the result is still unread.
module running_central_moments_order4_top
   import rcm_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   // [SAMPLE_BITS-1:0] sample
   input  wire  [REQ_DATA_BITS-1:0] req_tdata,
   // [0] restart
   input  wire  [0:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   // [23:0] obs_count, [55:24] mean_value, [119:56] sum_sq_dev,
   // [183:120] sum_cube_dev, [247:184] sum_quart_dev
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] saturated
   output logic [0:0]               rsp_tuser
);

   state_type                     state_ff;
   step_type                      step_ff;
   logic [SAMPLE_BITS-1:0]        sample_ff;
   logic [COUNT_BITS-1:0]         count_ff;
   logic signed [31:0]            mean_ff;
   logic [63:0]                   m2_ff, m3_ff, m4_ff;
   logic                          sat_ff;
   logic [COUNT_BITS-1:0]         n_ff;
   logic signed [DELTA_BITS-1:0]  delta_ff, dn_ff;
   logic [63:0]                   c_ff, sc_ff, tmp_ff, dn2_ff, e_ff;
   logic [63:0]                   u1_ff, u2_ff, t3_ff, a_ff, b_ff;
   logic                          rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0]      rsp_data_ff;
   logic                          rsp_user_ff;

   logic                          req_fire;
   logic signed [X_BITS-1:0]      x_val;
   logic signed [DELTA_BITS-1:0]  delta_c;
   logic [DELTA_BITS-1:0]         dmag;
   logic                          cnt_full;
   logic [COUNT_BITS-1:0]         n_c;
   logic [63:0]                   n64, nm2_mag, dn64, delta64, dn_mag;
   logic signed [DELTA_BITS-1:0]  q_ext;
   logic                          ts_neg, uses_ts;
   sat_type                       ts;
   logic [63:0]                   tmp_c;
   logic                          step_flag;
   sat_type                       f1_m4, f1_m3, f2_m4, f2_m3, f2_m2, f3_m4;
   logic signed [DELTA_BITS:0]    mean_sum;
   logic [DELTA_BITS-31:0]        mean_hi;
   logic [31:0]                   mean_c;
   logic                          mean_ovf;
   logic [31:0]                   cnt_ext;
   mul_req_type                   mul_req;
   mul_rsp_type                   mul_rsp;
   div_req_type                   div_req;
   div_rsp_type                   div_rsp;

   rcm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   rcm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;

   // setup: n, delta and divider start
   always_comb begin
      x_val    = {sample_ff, 16'd0};
      delta_c  = DELTA_BITS'(x_val) - DELTA_BITS'(mean_ff);
      dmag     = delta_c[DELTA_BITS-1] ? (DELTA_BITS'(0) - delta_c) : delta_c;
      cnt_full = &count_ff;
      n_c      = cnt_full ? count_ff : (count_ff + COUNT_BITS'(1));
      div_req.start    = state_ff == S_PREP;
      div_req.dividend = dmag[QUOT_BITS-1:0];
      div_req.divisor  = n_c;
      q_ext = DELTA_BITS'(div_rsp.quot);
   end

   // common operand forms
   always_comb begin
      n64     = 64'(n_ff);
      nm2_mag = (n_ff == COUNT_BITS'(1)) ? 64'd1 : (n64 - 64'd2);
      dn64    = 64'(dn_ff);
      delta64 = 64'(delta_ff);
      dn_mag  = mag64(dn64);
   end

   // operand select per multiplier step
   always_comb begin
      mul_req.start = state_ff == S_ISSU;
      mul_req.a     = n64;
      mul_req.b     = n64;
      mul_req.shift = SH_0;
      ts_neg        = 1'b0;
      uses_ts       = 1'b1;
      case (step_ff)
         ST_NN: begin
            uses_ts = 1'b0;
         end
         ST_T: begin
            mul_req.a = mag64(delta64);
            mul_req.b = dn_mag;
            mul_req.shift = SH_16;
            ts_neg = delta64[63] ^ dn64[63];
         end
         ST_TMP: begin
            mul_req.a = mag64(sc_ff);
            mul_req.b = n64 - 64'd1;
            ts_neg = sc_ff[63];
         end
         ST_DN2: begin
            mul_req.a = dn_mag;
            mul_req.b = dn_mag;
            mul_req.shift = SH_16;
         end
         ST_E: begin
            mul_req.a = dn2_ff;
            mul_req.b = c_ff;
            mul_req.shift = SH_16;
            uses_ts = 1'b0;
         end
         ST_U1: begin
            mul_req.a = tmp_ff;
            mul_req.b = e_ff;
            mul_req.shift = SH_32;
            uses_ts = 1'b0;
         end
         ST_V: begin
            mul_req.a = m2_ff;
            mul_req.b = dn2_ff;
            mul_req.shift = SH_32;
            uses_ts = 1'b0;
         end
         ST_U2: begin
            mul_req.a = sc_ff;
            mul_req.b = 64'd6;
            uses_ts = 1'b0;
         end
         ST_W: begin
            mul_req.a = mag64(m3_ff);
            mul_req.b = dn_mag;
            mul_req.shift = SH_16;
            ts_neg = m3_ff[63] ^ dn64[63];
         end
         ST_T3: begin
            mul_req.a = mag64(sc_ff);
            mul_req.b = 64'd4;
            ts_neg = sc_ff[63];
         end
         ST_A1: begin
            mul_req.a = tmp_ff;
            mul_req.b = dn_mag;
            mul_req.shift = SH_16;
            ts_neg = dn64[63];
         end
         ST_A: begin
            mul_req.a = mag64(sc_ff);
            mul_req.b = nm2_mag;
            mul_req.shift = SH_16;
            ts_neg = sc_ff[63] ^ (n_ff == COUNT_BITS'(1));
         end
         ST_B0: begin
            mul_req.a = m2_ff;
            mul_req.b = dn_mag;
            mul_req.shift = SH_32;
            ts_neg = dn64[63];
         end
         ST_B: begin
            mul_req.a = mag64(sc_ff);
            mul_req.b = 64'd3;
            ts_neg = sc_ff[63];
         end
         default: begin
            uses_ts = 1'b0;
         end
      endcase
      ts        = to_signed(mul_rsp.res, ts_neg);
      tmp_c     = ts.val[63] ? 64'd0 : ts.val;
      step_flag = (step_ff != ST_NN) && (mul_rsp.ovf || (uses_ts && ts.ovf));
   end

   // saturating accumulation and mean clamp
   always_comb begin
      f1_m4    = uadd(m4_ff, u1_ff);
      f1_m3    = sadd(m3_ff, a_ff);
      f2_m4    = uadd(m4_ff, u2_ff);
      f2_m3    = ssub(m3_ff, b_ff);
      f2_m2    = uadd(m2_ff, tmp_ff);
      if (!t3_ff[63] && (|t3_ff)) begin
         f3_m4 = usub(m4_ff, t3_ff);
      end else begin
         f3_m4 = uadd(m4_ff, mag64(t3_ff));
      end
      mean_sum = (DELTA_BITS + 1)'(mean_ff) + (DELTA_BITS + 1)'(dn_ff);
      mean_hi  = mean_sum[DELTA_BITS:31];
      mean_ovf = !((&mean_hi) || !(|mean_hi));
      if (mean_ovf) begin
         mean_c = mean_sum[DELTA_BITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         mean_c = mean_sum[31:0];
      end
      cnt_ext = 32'(count_ff);
   end

   // sequencer and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_NN;
         count_ff     <= '0;
         mean_ff      <= '0;
         m2_ff        <= '0;
         m3_ff        <= '0;
         m4_ff        <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_tuser[0]) begin
                     count_ff <= '0;
                     mean_ff  <= '0;
                     m2_ff    <= '0;
                     m3_ff    <= '0;
                     m4_ff    <= '0;
                     sat_ff   <= 1'b0;
                  end
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               if (cnt_full) begin
                  sat_ff <= 1'b1;
               end
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  step_ff  <= ST_NN;
                  state_ff <= S_ISSU;
               end
            end
            S_ISSU: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (mul_rsp.done) begin
                  if (step_flag) begin
                     sat_ff <= 1'b1;
                  end
                  if (step_ff == ST_B) begin
                     state_ff <= S_FIN1;
                  end else begin
                     step_ff  <= step_type'(step_ff + 4'd1);
                     state_ff <= S_ISSU;
                  end
               end
            end
            S_FIN1: begin
               m4_ff <= f1_m4.val;
               m3_ff <= f1_m3.val;
               if (f1_m4.ovf || f1_m3.ovf) begin
                  sat_ff <= 1'b1;
               end
               state_ff <= S_FIN2;
            end
            S_FIN2: begin
               m4_ff    <= f2_m4.val;
               m3_ff    <= f2_m3.val;
               m2_ff    <= f2_m2.val;
               mean_ff  <= mean_c;
               count_ff <= n_ff;
               if (f2_m4.ovf || f2_m3.ovf || f2_m2.ovf || mean_ovf) begin
                  sat_ff <= 1'b1;
               end
               state_ff <= S_FIN3;
            end
            S_FIN3: begin
               m4_ff <= f3_m4.val;
               if (f3_m4.ovf) begin
                  sat_ff <= 1'b1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // working registers of one transaction
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (state_ff == S_PREP) begin
         n_ff     <= n_c;
         delta_ff <= delta_c;
      end
      if ((state_ff == S_DIV) && div_rsp.done) begin
         dn_ff <= delta_ff[DELTA_BITS-1] ? (DELTA_BITS'(0) - q_ext) : q_ext;
      end
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {m4_ff, m3_ff, m2_ff, mean_ff, cnt_ext[23:0]};
         rsp_user_ff <= sat_ff;
      end
      if ((state_ff == S_WAIT) && mul_rsp.done) begin
         case (step_ff)
            ST_NN:  c_ff   <= mul_rsp.res + 64'd3 - (n64 + (n64 << 1));
            ST_T:   sc_ff  <= ts.val;
            ST_TMP: tmp_ff <= tmp_c;
            ST_DN2: dn2_ff <= ts.val;
            ST_E:   e_ff   <= mul_rsp.res;
            ST_U1:  u1_ff  <= mul_rsp.res;
            ST_V:   sc_ff  <= mul_rsp.res;
            ST_U2:  u2_ff  <= mul_rsp.res;
            ST_W:   sc_ff  <= ts.val;
            ST_T3:  t3_ff  <= ts.val;
            ST_A1:  sc_ff  <= ts.val;
            ST_A:   a_ff   <= ts.val;
            ST_B0:  sc_ff  <= ts.val;
            ST_B:   b_ff   <= ts.val;
            default: begin
               sc_ff <= sc_ff;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // checks on the sequencer
   `RCM_ASSERT(a_mul_done_in_wait, clock, reset, mul_rsp.done |-> (state_ff == S_WAIT))
   `RCM_ASSERT(a_div_done_in_div, clock, reset, div_rsp.done |-> (state_ff == S_DIV))
   `RCM_NEVER(a_ready_while_mul_busy, clock, reset, req_tready && mul_rsp.busy)
   `RCM_ASSERT(a_sat_sticky, clock, reset, (sat_ff && !(req_fire && req_tuser[0])) |=> sat_ff)

endmodule

`default_nettype wire

/* test/rcm_moment_checker.sv */
// checker for the central moments block: predicts every result and compares it
`default_nettype none

module rcm_moment_checker
   import rcm_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   input  wire                      req_tready,
   input  wire  [REQ_DATA_BITS-1:0] req_tdata,
   input  wire  [0:0]               req_tuser,
   input  wire                      rsp_tvalid,
   input  wire                      rsp_tready,
   input  wire  [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire  [0:0]               rsp_tuser,
   output int                       errors,
   output int                       pending
);

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
   localparam longint          S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint          S64_MIN   = 64'sh8000_0000_0000_0000;
   localparam longint unsigned U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [23:0] obs_count;
      logic [31:0] mean_value;
      logic [63:0] sum_sq_dev;
      logic [63:0] sum_cube_dev;
      logic [63:0] sum_quart_dev;
      logic        saturated;
   } moments_type;

   // running statistics of the predictor
   longint unsigned obs_n;
   int              run_mean;
   longint unsigned run_m2;
   longint          run_m3;
   longint unsigned run_m4;
   bit              sat_seen;

   moments_type expected_moments[$];

   // (a*b) >> s exact at 128 bits, clamped to 64 bits
   function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                  int s);
      logic [127:0] p;
      logic [127:0] q;
      p = {64'd0, a} * {64'd0, b};
      q = p >> s;
      if (q[127:64] != 0) begin
         sat_seen = 1'b1;
         return U64_MAX;
      end
      return q[63:0];
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(64'd0 - v) : v;
   endfunction

   function automatic longint apply_sign(longint unsigned m, bit neg);
      if (!neg) begin
         if (m > longint'(S64_MAX)) begin
            sat_seen = 1'b1;
            return S64_MAX;
         end
         return m;
      end
      if (m > (64'd1 << 63)) begin
         sat_seen = 1'b1;
         return S64_MIN;
      end
      return longint'(64'd0 - m);
   endfunction

   function automatic longint signed_mul(longint a, longint b, int s);
      return apply_sign(mul_shift(magnitude(a), magnitude(b), s), (a < 0) != (b < 0));
   endfunction

   function automatic longint signed_add(longint a, longint b);
      if (b > 0 && a > S64_MAX - b) begin
         sat_seen = 1'b1;
         return S64_MAX;
      end
      if (b < 0 && a < S64_MIN - b) begin
         sat_seen = 1'b1;
         return S64_MIN;
      end
      return a + b;
   endfunction

   function automatic longint signed_sub(longint a, longint b);
      if (b < 0 && a > S64_MAX + b) begin
         sat_seen = 1'b1;
         return S64_MAX;
      end
      if (b > 0 && a < S64_MIN + b) begin
         sat_seen = 1'b1;
         return S64_MIN;
      end
      return a - b;
   endfunction

   function automatic longint unsigned unsigned_add(longint unsigned a, longint unsigned b);
      if (a > U64_MAX - b) begin
         sat_seen = 1'b1;
         return U64_MAX;
      end
      return a + b;
   endfunction

   function automatic longint unsigned unsigned_sub(longint unsigned a, longint unsigned b);
      if (b > a) begin
         sat_seen = 1'b1;
         return 64'd0;
      end
      return a - b;
   endfunction

   // one-pass update of count, mean and moment sums for one sample
   function automatic moments_type advance_moments(logic signed [SAMPLE_BITS-1:0] sample,
                                                   bit restart);
      moments_type     r;
      longint unsigned n, c, e, u1, u2, m4_next;
      longint          x, delta, dn, t, tmp, dn2, t3, a, b, m3_next, mean_next;
      if (restart) begin
         obs_n    = 0;
         run_mean = 0;
         run_m2   = 0;
         run_m3   = 0;
         run_m4   = 0;
         sat_seen = 1'b0;
      end
      x = longint'(sample) * 65536;
      if (obs_n >= COUNT_MAX) begin
         n        = COUNT_MAX;
         sat_seen = 1'b1;
      end else begin
         n = obs_n + 1;
      end
      delta = x - longint'(run_mean);
      dn    = delta / longint'(n);
      t     = signed_mul(delta, dn, 16);
      tmp   = signed_mul(t, longint'(n) - 1, 0);
      if (tmp < 0) tmp = 0;

      // fourth moment from the old second and third sums
      c       = n * n + 3 - 3 * n;
      dn2     = signed_mul(dn, dn, 16);
      e       = mul_shift(magnitude(dn2), c, 16);
      u1      = mul_shift(tmp, e, 32);
      u2      = mul_shift(mul_shift(run_m2, magnitude(dn2), 32), 6, 0);
      t3      = signed_mul(signed_mul(run_m3, dn, 16), 4, 0);
      m4_next = unsigned_add(run_m4, u1);
      m4_next = unsigned_add(m4_next, u2);
      if (t3 > 0) m4_next = unsigned_sub(m4_next, magnitude(t3));
      else m4_next = unsigned_add(m4_next, magnitude(t3));

      // third moment from the old second sum
      a       = signed_mul(signed_mul(tmp, dn, 16), longint'(n) - 2, 16);
      b       = signed_mul(apply_sign(mul_shift(run_m2, magnitude(dn), 32), dn < 0), 3, 0);
      m3_next = signed_add(run_m3, a);
      m3_next = signed_sub(m3_next, b);

      run_m2 = unsigned_add(run_m2, tmp);
      run_m3 = m3_next;
      run_m4 = m4_next;

      mean_next = longint'(run_mean) + dn;
      if (mean_next > 64'sd2147483647) begin
         mean_next = 64'sd2147483647;
         sat_seen  = 1'b1;
      end
      if (mean_next < -64'sd2147483648) begin
         mean_next = -64'sd2147483648;
         sat_seen  = 1'b1;
      end
      run_mean = int'(mean_next);
      obs_n    = n;

      r.obs_count     = obs_n[23:0];
      r.mean_value    = run_mean;
      r.sum_sq_dev    = run_m2;
      r.sum_cube_dev  = run_m3;
      r.sum_quart_dev = run_m4;
      r.saturated     = sat_seen;
      return r;
   endfunction

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("rcm mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
      errors++;
   endtask

   // compare results against the oldest prediction, then predict new samples
   always @(posedge clock) begin
      moments_type got, want;
      if (reset) begin
         obs_n    = 0;
         run_mean = 0;
         run_m2   = 0;
         run_m3   = 0;
         run_m4   = 0;
         sat_seen = 1'b0;
         expected_moments.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            // tdata carries obs_count in its lowest bits
            got = {rsp_tdata[23:0], rsp_tdata[55:24], rsp_tdata[119:56],
                   rsp_tdata[183:120], rsp_tdata[247:184], rsp_tuser[0]};
            if (expected_moments.size() == 0) begin
               $display("rcm unexpected result transaction at %0t", $realtime);
               errors++;
            end else begin
               want = expected_moments.pop_front();
               if (got.obs_count != want.obs_count)
                  report("obs_count", got.obs_count, want.obs_count);
               if (got.mean_value != want.mean_value)
                  report("mean_value", got.mean_value, want.mean_value);
               if (got.sum_sq_dev != want.sum_sq_dev)
                  report("sum_sq_dev", got.sum_sq_dev, want.sum_sq_dev);
               if (got.sum_cube_dev != want.sum_cube_dev)
                  report("sum_cube_dev", got.sum_cube_dev, want.sum_cube_dev);
               if (got.sum_quart_dev != want.sum_quart_dev)
                  report("sum_quart_dev", got.sum_quart_dev, want.sum_quart_dev);
               if (got.saturated != want.saturated)
                  report("saturated", got.saturated, want.saturated);
            end
         end
         if (req_tvalid && req_tready)
            expected_moments.push_back(advance_moments(req_tdata[SAMPLE_BITS-1:0],
                                                       req_tuser[0]));
      end
      pending = expected_moments.size();
   end

   initial begin
      errors  = 0;
      pending = 0;
   end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// testbench top: drives samples and result stalls, gives the verdict
`default_nettype none

module tb_top
   import rcm_pkg::*;
;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 1930;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [0:0]               req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;
   int                       errors;
   int                       pending;
   int                       cycles;
   int                       burst_left;
   bit                       long_hold;

   running_central_moments_order4_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rcm_moment_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: stall pattern is picked anew after each random span, plus one long hold
   initial begin
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(8, 80);
         repeat (span) begin
            @(negedge clock);
            if (long_hold) begin
               long_hold  = 1'b0;
               rsp_tready = 1'b0;
               repeat (3000) @(negedge clock);
            end
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               default: rsp_tready = ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // offer one sample and wait for its transaction; gaps come between bursts
   task automatic send_sample(logic [SAMPLE_BITS-1:0] sample, bit restart);
      req_tdata  = sample;
      req_tuser  = restart;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12))
            @(negedge clock);
         burst_left = $urandom_range(0, 25);
      end
   endtask

   // random sample of a chosen flavor
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(int flavor, int base);
      case (flavor)
         0: return SAMPLE_BITS'($urandom);
         1: return SAMPLE_BITS'(base + int'($urandom_range(0, 31)) - 16);
         2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return SAMPLE_BITS'(base);
      endcase
   endfunction

   initial begin
      int run_len;
      int flavor;
      int base;
      int sent;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      long_hold  = 1'b0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, sign flips, restarts mid-stream
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h5555, 1'b1);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h1234, 1'b0);

      // pause until every result is back
      req_tvalid = 1'b0;
      wait (pending == 0);
      @(negedge clock);

      // random runs, most start with a restart
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         run_len = $urandom_range(1, 60);
         flavor  = $urandom_range(0, 3);
         base    = $urandom;
         for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
            if (sent == 400) long_hold = 1'b1;
            if (sent == 1000) begin
               req_tvalid = 1'b0;
               wait (pending == 0);
               @(negedge clock);
            end
            send_sample(pick_sample(($urandom_range(0, 9) == 0) ? 0 : flavor, base),
                        (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 99) == 0));
            sent++;
         end
      end

      // drain
      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* running_central_moments_order4_top.f */
+incdir+src
src/rcm_pkg.sv
src/rcm_mul.sv
src/rcm_div.sv
src/running_central_moments_order4_top.sv
test/rcm_moment_checker.sv
test/tb_top.sv
